// ===== rtl/core/dwsd_pkg.sv =====
`default_nettype none

package dwsd_pkg;

    localparam int STACK_DEPTH   = 16;
    localparam int HISTORY_DEPTH = 64;

    localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int LVL_W  = 5;

    localparam logic [2:0] STATUS_QUEUED   = 3'd0;
    localparam logic [2:0] STATUS_DUP      = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_DISPATCH = 3'd3;
    localparam logic [2:0] STATUS_NO_WORK  = 3'd4;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_HALTED   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  core_id;
        logic [15:0] req_current_node;
        logic [15:0] req_next_node;
        logic [7:0]  req_walk_state;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       target_core;
        logic [15:0]      out_current_node;
        logic [15:0]      out_next_node;
        logic [7:0]       out_walk_state;
        logic [LVL_W-1:0] stack_level;
    } t_out_word;

    typedef struct packed {
        logic [15:0] cur;
        logic [15:0] nxt;
        logic [7:0]  ws;
    } t_ctx;

    // travels down the history chain, one cell per cycle
    typedef struct packed {
        logic              vld;
        logic [FILL_W-1:0] remaining;
        logic              hit;
    } t_probe;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/dwsd_hist_cell.sv =====
`default_nettype none

module dwsd_hist_cell
    import dwsd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_shift,
    input  wire t_ctx   i_entry_prev,
    input  wire t_ctx   i_key,
    input  wire t_probe i_probe,
    output t_ctx        o_entry,
    output t_probe      o_probe
);

    t_ctx   r_entry;
    t_probe r_probe;
    t_probe n_probe;

    always_comb begin
        n_probe = i_probe;
        if (i_probe.remaining != '0) begin
            n_probe.remaining = i_probe.remaining - FILL_W'(1);
            n_probe.hit       = i_probe.hit | (r_entry == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.vld <= 1'b0;
        end else begin
            r_probe.vld <= n_probe.vld;
        end
        r_probe.remaining <= n_probe.remaining;
        r_probe.hit       <= n_probe.hit;
    end

    // newest entry enters at the head; the oldest falls off the tail
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== rtl/core/dwsd_stack_cell.sv =====
`default_nettype none

module dwsd_stack_cell
    import dwsd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_stk_ctrl i_ctrl,
    input  wire t_ctx      i_from_above,
    input  wire t_ctx      i_from_below,
    output t_ctx           o_ctx
);

    t_ctx r_ctx;

    // push moves everything one cell deeper, pop pulls it back up
    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.push) begin
            r_ctx <= i_from_above;
        end else if (i_ctrl.pop) begin
            r_ctx <= i_from_below;
        end
    end

    assign o_ctx = r_ctx;

endmodule

`default_nettype wire

// ===== rtl/core/dedup_work_stack_dispatcher_top.sv =====
`default_nettype none

// Deduplicating work-stack dispatcher. One event is taken at a time and
// answered with one result word. The work stack is a row of STACK_DEPTH
// shifting cells with its top in the first cell; the history of dispatched
// contexts is a row of HISTORY_DEPTH cells where the newest entry enters at
// the head and the oldest drops off the tail. A schedule request on a stack
// that is not full sends a probe down the history row, one cell per cycle;
// the next word is accepted only after the probe has left the last cell and
// the result has been loaded. A halted event, or a request refused because
// the stack is full, goes straight to the result. A finished result sits
// in the output register while the next word is accepted.
module dedup_work_stack_dispatcher_top
    import dwsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    t_state r_state;
    t_state n_state;

    t_in_word          r_item;
    logic              r_hit;
    logic              r_launch;
    logic [SCNT_W-1:0] r_count;
    logic [SCNT_W-1:0] n_count;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_out_vld;
    t_out_word         r_out_word;
    t_out_word         n_out_word;

    logic      w_accept;
    logic      w_load;
    logic      w_to_search;
    logic      w_record;
    t_stk_ctrl w_stk_ctrl;
    t_ctx      w_key;
    t_ctx      w_top;
    t_probe    w_probe_head;

    t_ctx   w_stk  [STACK_DEPTH];
    t_ctx   w_hist [HISTORY_DEPTH];
    t_probe w_probe[HISTORY_DEPTH];

    assign w_key = '{cur: r_item.req_current_node,
                     nxt: r_item.req_next_node,
                     ws:  r_item.req_walk_state};
    assign w_top = w_stk[0];

    assign w_to_search = (i_in_word.opcode == OP_SCHEDULE) &&
                         (r_count != SCNT_W'(STACK_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_to_search ? S_SEARCH : S_RESULT;
                end
            end
            S_SEARCH: begin
                if (w_probe[HISTORY_DEPTH-1].vld) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_SEARCH: ;
            S_RESULT: w_load = !r_out_vld || i_out_ready;
            default:  ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // result and state update, applied when the output slot is free
    always_comb begin
        n_out_word             = '0;
        n_out_word.target_core = r_item.core_id;
        n_count                = r_count;
        n_fill                 = r_fill;
        w_stk_ctrl             = '0;
        w_record               = 1'b0;
        if (r_item.opcode == OP_SCHEDULE) begin
            priority if (r_count == SCNT_W'(STACK_DEPTH)) begin
                n_out_word.status = STATUS_FULL;
            end else if (r_hit) begin
                n_out_word.status = STATUS_DUP;
            end else begin
                n_out_word.status = STATUS_QUEUED;
                w_stk_ctrl.push   = w_load;
                n_count           = r_count + SCNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_out_word.status = STATUS_NO_WORK;
            end else begin
                n_out_word.status           = STATUS_DISPATCH;
                n_out_word.out_current_node = w_top.cur;
                n_out_word.out_next_node    = w_top.nxt;
                n_out_word.out_walk_state   = w_top.ws;
                w_stk_ctrl.pop              = w_load;
                w_record                    = w_load;
                n_count                     = r_count - SCNT_W'(1);
                if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
            end
        end
        n_out_word.stack_level = LVL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
            r_launch  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && w_to_search;
            if (w_load) begin
                r_count   <= n_count;
                r_fill    <= n_fill;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_word;
            r_hit  <= 1'b0;
        end else if (w_probe[HISTORY_DEPTH-1].vld) begin
            r_hit <= w_probe[HISTORY_DEPTH-1].hit;
        end
        if (w_load) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // work stack row
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stk
        t_ctx w_above;
        t_ctx w_below;
        if (i == 0) begin : g_head
            assign w_above = w_key;
        end else begin : g_body
            assign w_above = w_stk[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign w_below = w_stk[i];
        end else begin : g_inner
            assign w_below = w_stk[i+1];
        end
        dwsd_stack_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_stk_ctrl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_ctx        (w_stk[i])
        );
    end

    // history row; the probe only checks the first r_fill cells
    assign w_probe_head = '{vld: r_launch, remaining: r_fill, hit: 1'b0};

    for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_hist
        t_ctx   w_prev;
        t_probe w_pin;
        if (j == 0) begin : g_head
            assign w_prev = w_top;
            assign w_pin  = w_probe_head;
        end else begin : g_body
            assign w_prev = w_hist[j-1];
            assign w_pin  = w_probe[j-1];
        end
        dwsd_hist_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_record),
            .i_entry_prev (w_prev),
            .i_key        (w_key),
            .i_probe      (w_pin),
            .o_entry      (w_hist[j]),
            .o_probe      (w_probe[j])
        );
    end

`ifndef ASSERT_OFF
    a_probe_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[HISTORY_DEPTH-1].vld |-> r_state == S_SEARCH)
        else $error("probe left the history row outside a search");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SCNT_W'(STACK_DEPTH) && r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("stack or history count out of range");

    a_pop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out_word.status == STATUS_DISPATCH)
        |=> r_count == $past(r_count) - SCNT_W'(1))
        else $error("dispatch did not lower the stack level");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !o_in_ready && !w_load)
        else $error("word taken or result loaded during a search");
`endif

endmodule

`default_nettype wire
